/* rtl/core/grc_pkg.sv */
// ----------------------------------------------------------------------------
// grc_pkg
// Shared widths, register indexes, reset values and pipeline word types of
// the gradient row color block.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int ROW_W   = 12;
    localparam int RC_W    = 13;
    localparam int SCNT_W  = 3;
    localparam int STOP_W  = 41;
    localparam int POS_W   = 17;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int FRAC_W  = 16;
    localparam int TGT_W   = ROW_W + FRAC_W;
    localparam int PROD_W  = POS_W + RC_W;
    localparam int DIFF_W  = PROD_W + 2;
    localparam int W_W     = CHAN_W + 1;
    localparam int DIV_STEPS = CHAN_W;

    localparam logic [W_W-1:0] W_ONE  = 9'd256;
    localparam logic [W_W-1:0] W_ZERO = 9'd0;

    // register indexes of the configuration port
    localparam int REG_ROW_COUNT  = 0;
    localparam int REG_STOP_COUNT = 1;
    localparam int REG_STOP_BASE  = 2;

    localparam logic [RC_W-1:0]   ROW_COUNT_RST  = 13'd256;
    localparam logic [SCNT_W-1:0] STOP_COUNT_RST = 3'd2;
    localparam logic [SCNT_W-1:0] STOP_COUNT_MIN = 3'd2;
    localparam logic [STOP_W-1:0] STOP_FIRST_RST = 41'h000_00FF_FFFF;
    localparam logic [STOP_W-1:0] STOP_OTHER_RST = 41'h100_0000_0000;

    typedef struct packed {
        logic               found;
        logic [DIFF_W-1:0]  num;
        logic [DIFF_W-1:0]  den;
        logic [COLOR_W-1:0] c1;
        logic [COLOR_W-1:0] c2;
    } seg_word_t;

    typedef struct packed {
        logic [W_W-1:0]     w;
        logic [COLOR_W-1:0] c1;
        logic [COLOR_W-1:0] c2;
    } blend_word_t;

endpackage

/* rtl/core/gradient_row_color.sv */
// ----------------------------------------------------------------------------
// gradient_row_color
// Color of one row of a vertical multi-stop linear gradient.
// ----------------------------------------------------------------------------
// Takes one row number per cycle while the output is not stalled and returns
// its RGB color through the segment search stages, the weight stages (edge
// cases, then an eight-stage restoring divider that yields one weight bit per
// stage) and the channel blending stage into the output register. Every stage
// stalls on its own, so bubbles are squeezed out and s_tready stays high
// whenever m_tready is high. Configuration writes take effect at once and must
// only be made while no row is in flight.
// ----------------------------------------------------------------------------
module gradient_row_color #(
    parameter int MAX_STOPS = 6,
    parameter int MAX_ROWS  = 4096
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   s_tvalid,
    output logic                                                   s_tready,
    input  logic [15:0]                                            s_tdata,   // row, zero pad
    output logic                                                   m_tvalid,
    input  logic                                                   m_tready,
    output logic [23:0]                                            m_tdata,   // red, green, blue
    input  logic                                                   cfg_wen,
    input  logic [$clog2(grc_pkg::REG_STOP_BASE + MAX_STOPS)-1:0]  cfg_index,
    input  logic [grc_pkg::STOP_W-1:0]                             cfg_wdata
);
    import grc_pkg::*;

    localparam int IDX_W = $clog2(REG_STOP_BASE + MAX_STOPS);

    logic [RC_W-1:0]    rc;
    logic [SCNT_W-1:0]  n_stops;
    logic [POS_W-1:0]   pos [MAX_STOPS];
    logic [COLOR_W-1:0] col [MAX_STOPS];

    seg_word_t   seg_word;
    logic        seg_valid;
    logic        seg_ready;
    blend_word_t div_word;
    logic        div_valid;
    logic        div_ready;

    grc_cfg #(
        .MAX_STOPS (MAX_STOPS),
        .MAX_ROWS  (MAX_ROWS),
        .IDX_W     (IDX_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rc        (rc),
        .n_stops   (n_stops),
        .pos       (pos),
        .col       (col)
    );

    grc_seg #(
        .MAX_STOPS (MAX_STOPS)
    ) u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_row    (s_tdata[ROW_W-1:0]),
        .rc        (rc),
        .n_stops   (n_stops),
        .pos       (pos),
        .col       (col),
        .out_valid (seg_valid),
        .out_ready (seg_ready),
        .out_word  (seg_word)
    );

    grc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .in_word   (seg_word),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_word  (div_word)
    );

    grc_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_word   (div_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rgb   (m_tdata)
    );

endmodule

/* rtl/core/grc_cfg.sv */
// ----------------------------------------------------------------------------
// grc_cfg
// Configuration registers with range clamping of row count and stop count.
// ----------------------------------------------------------------------------
module grc_cfg #(
    parameter int MAX_STOPS = 6,
    parameter int MAX_ROWS  = 4096,
    parameter int IDX_W     = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [IDX_W-1:0]               cfg_index,
    input  logic [grc_pkg::STOP_W-1:0]     cfg_wdata,
    output logic [grc_pkg::RC_W-1:0]       rc,
    output logic [grc_pkg::SCNT_W-1:0]     n_stops,
    output logic [grc_pkg::POS_W-1:0]      pos [MAX_STOPS],
    output logic [grc_pkg::COLOR_W-1:0]    col [MAX_STOPS]
);
    import grc_pkg::*;

    logic [RC_W-1:0]   row_count_reg;
    logic [SCNT_W-1:0] stop_count_reg;
    logic [STOP_W-1:0] stop_reg [MAX_STOPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= ROW_COUNT_RST;
            stop_count_reg <= STOP_COUNT_RST;
        end
        else if (cfg_wen)
        begin
            if (cfg_index == IDX_W'(REG_ROW_COUNT))
                row_count_reg <= cfg_wdata[RC_W-1:0];
            if (cfg_index == IDX_W'(REG_STOP_COUNT))
                stop_count_reg <= cfg_wdata[SCNT_W-1:0];
        end
    end

    for (genvar i = 0; i < MAX_STOPS; i++)
    begin : g_stop
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                stop_reg[i] <= (i == 0) ? STOP_FIRST_RST : STOP_OTHER_RST;
            else if (cfg_wen && cfg_index == IDX_W'(REG_STOP_BASE + i))
                stop_reg[i] <= cfg_wdata;
        end
        assign pos[i] = stop_reg[i][COLOR_W +: POS_W];
        assign col[i] = stop_reg[i][COLOR_W-1:0];
    end

    always_comb
    begin
        if (row_count_reg == '0)
            rc = RC_W'(1);
        else if (32'(row_count_reg) > MAX_ROWS)
            rc = RC_W'(MAX_ROWS);
        else
            rc = row_count_reg;

        if (stop_count_reg < STOP_COUNT_MIN)
            n_stops = STOP_COUNT_MIN;
        else if (32'(stop_count_reg) > MAX_STOPS)
            n_stops = SCNT_W'(MAX_STOPS);
        else
            n_stops = stop_count_reg;
    end

endmodule

/* rtl/core/grc_seg.sv */
// ----------------------------------------------------------------------------
// grc_seg
// Three-stage front end: scaled stop positions, segment search, and the
// numerator and denominator of the blend weight.
// ----------------------------------------------------------------------------
module grc_seg #(
    parameter int MAX_STOPS = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [grc_pkg::ROW_W-1:0]      in_row,
    input  logic [grc_pkg::RC_W-1:0]       rc,
    input  logic [grc_pkg::SCNT_W-1:0]     n_stops,
    input  logic [grc_pkg::POS_W-1:0]      pos [MAX_STOPS],
    input  logic [grc_pkg::COLOR_W-1:0]    col [MAX_STOPS],
    output logic                           out_valid,
    input  logic                           out_ready,
    output grc_pkg::seg_word_t             out_word
);
    import grc_pkg::*;

    localparam int S = 3;

    logic [S-1:0] v_reg;
    logic [S-1:0] v_next;
    logic [S-1:0] en;

    for (genvar i = 0; i < S; i++)
    begin : g_ctl
        if (i == S - 1)
        begin : g_last
            assign en[i] = !v_reg[i] || out_ready;
        end
        else
        begin : g_mid
            assign en[i] = !v_reg[i] || en[i+1];
        end
        if (i == 0)
        begin : g_first
            assign v_next[i] = en[i] ? in_valid : v_reg[i];
        end
        else
        begin : g_rest
            assign v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[S-1];

    // stage 0: positions scaled by row count
    logic [ROW_W-1:0]  row0_reg;
    logic [PROD_W-1:0] prod0_reg [MAX_STOPS];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            row0_reg <= in_row;
            for (int k = 0; k < MAX_STOPS; k++)
                prod0_reg[k] <= PROD_W'(pos[k]) * PROD_W'(rc);
        end
    end

    // stage 1: first segment whose end reaches the row
    logic [TGT_W-1:0]   tgt0;
    logic               found1;
    logic [PROD_W-1:0]  lo1;
    logic [PROD_W-1:0]  hi1;
    logic [COLOR_W-1:0] c11;
    logic [COLOR_W-1:0] c21;
    logic [COLOR_W-1:0] last_col;

    assign tgt0 = {row0_reg, FRAC_W'(0)};

    always_comb
    begin
        last_col = col[MAX_STOPS-1];
        for (int k = 0; k < MAX_STOPS; k++)
            if (SCNT_W'(k + 1) == n_stops)
                last_col = col[k];

        found1 = 1'b0;
        lo1    = '0;
        hi1    = '0;
        c11    = last_col;
        c21    = last_col;
        for (int k = MAX_STOPS - 1; k >= 1; k--)
        begin
            if (SCNT_W'(k) < n_stops && prod0_reg[k] >= PROD_W'(tgt0))
            begin
                found1 = 1'b1;
                lo1    = prod0_reg[k-1];
                hi1    = prod0_reg[k];
                c11    = col[k-1];
                c21    = col[k];
            end
        end
    end

    logic [ROW_W-1:0]   row1_reg;
    logic               found1_reg;
    logic [PROD_W-1:0]  lo1_reg;
    logic [PROD_W-1:0]  hi1_reg;
    logic [COLOR_W-1:0] c11_reg;
    logic [COLOR_W-1:0] c21_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            row1_reg   <= row0_reg;
            found1_reg <= found1;
            lo1_reg    <= lo1;
            hi1_reg    <= hi1;
            c11_reg    <= c11;
            c21_reg    <= c21;
        end
    end

    // stage 2: signed numerator and denominator
    seg_word_t word2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            word2_reg.found <= found1_reg;
            word2_reg.num   <= DIFF_W'({row1_reg, FRAC_W'(0)}) - DIFF_W'(lo1_reg);
            word2_reg.den   <= DIFF_W'(hi1_reg) - DIFF_W'(lo1_reg);
            word2_reg.c1    <= c11_reg;
            word2_reg.c2    <= c21_reg;
        end
    end

    assign out_word = word2_reg;

endmodule

/* rtl/core/grc_div.sv */
// ----------------------------------------------------------------------------
// grc_div
// Weight pipeline: edge case sorting, then one quotient bit per stage of a
// restoring divider.
// ----------------------------------------------------------------------------
module grc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  grc_pkg::seg_word_t   in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output grc_pkg::blend_word_t out_word
);
    import grc_pkg::*;

    localparam int S     = DIV_STEPS + 1;
    localparam int REM_W = PROD_W;

    logic [S-1:0] v_reg;
    logic [S-1:0] v_next;
    logic [S-1:0] en;

    for (genvar i = 0; i < S; i++)
    begin : g_ctl
        if (i == S - 1)
        begin : g_last
            assign en[i] = !v_reg[i] || out_ready;
        end
        else
        begin : g_mid
            assign en[i] = !v_reg[i] || en[i+1];
        end
        if (i == 0)
        begin : g_first
            assign v_next[i] = en[i] ? in_valid : v_reg[i];
        end
        else
        begin : g_rest
            assign v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[S-1];

    logic               spec_reg [S];
    logic [W_W-1:0]     wsp_reg  [S];
    logic [REM_W-1:0]   rem_reg  [S];
    logic [REM_W-1:0]   den_reg  [S];
    logic [CHAN_W-1:0]  q_reg    [S];
    logic [COLOR_W-1:0] c1_reg   [S];
    logic [COLOR_W-1:0] c2_reg   [S];

    // stage 0: edge cases
    logic signed [DIFF_W-1:0] num_s;
    logic signed [DIFF_W-1:0] den_s;
    logic                     spec0;
    logic [W_W-1:0]           wsp0;

    assign num_s = signed'(in_word.num);
    assign den_s = signed'(in_word.den);

    always_comb
    begin
        spec0 = 1'b1;
        wsp0  = W_ONE;
        if (!in_word.found || den_s <= 0)
            wsp0 = W_ONE;
        else if (num_s <= 0)
            wsp0 = W_ZERO;
        else if (num_s >= den_s)
            wsp0 = W_ONE;
        else
            spec0 = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            spec_reg[0] <= spec0;
            wsp_reg[0]  <= wsp0;
            rem_reg[0]  <= in_word.num[REM_W-1:0];
            den_reg[0]  <= in_word.den[REM_W-1:0];
            q_reg[0]    <= '0;
            c1_reg[0]   <= in_word.c1;
            c2_reg[0]   <= in_word.c2;
        end
    end

    // stages 1..DIV_STEPS: one quotient bit each
    for (genvar i = 1; i < S; i++)
    begin : g_step
        logic [REM_W:0] rem2;
        logic           ge;

        assign rem2 = {rem_reg[i-1], 1'b0};
        assign ge   = rem2 >= {1'b0, den_reg[i-1]};

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                spec_reg[i] <= spec_reg[i-1];
                wsp_reg[i]  <= wsp_reg[i-1];
                rem_reg[i]  <= ge ? REM_W'(rem2 - {1'b0, den_reg[i-1]}) : rem2[REM_W-1:0];
                den_reg[i]  <= den_reg[i-1];
                q_reg[i]    <= {q_reg[i-1][CHAN_W-2:0], ge};
                c1_reg[i]   <= c1_reg[i-1];
                c2_reg[i]   <= c2_reg[i-1];
            end
        end
    end

    assign out_word.w  = spec_reg[S-1] ? wsp_reg[S-1] : {1'b0, q_reg[S-1]};
    assign out_word.c1 = c1_reg[S-1];
    assign out_word.c2 = c2_reg[S-1];

endmodule

/* rtl/core/grc_blend.sv */
// ----------------------------------------------------------------------------
// grc_blend
// Weighted mix of the two stop colors per channel with round half up,
// held in the output register.
// ----------------------------------------------------------------------------
module grc_blend (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  grc_pkg::blend_word_t              in_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [grc_pkg::COLOR_W-1:0]       out_rgb
);
    import grc_pkg::*;

    localparam int NCH   = COLOR_W / CHAN_W;
    localparam int ACC_W = W_W + CHAN_W;

    logic               v_reg;
    logic               v_next;
    logic               en;
    logic [COLOR_W-1:0] rgb_reg;
    logic [COLOR_W-1:0] rgb_next;
    logic [W_W-1:0]     wc;

    assign en        = !v_reg || out_ready;
    assign v_next    = en ? in_valid : v_reg;
    assign in_ready  = en;
    assign out_valid = v_reg;
    assign wc        = W_ONE - in_word.w;

    // output order is red low, blue high; stop colors hold red high
    always_comb
    begin
        logic [ACC_W-1:0] acc;
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        rgb_next = '0;
        for (int c = 0; c < NCH; c++)
        begin
            a   = in_word.c1[(NCH - 1 - c) * CHAN_W +: CHAN_W];
            b   = in_word.c2[(NCH - 1 - c) * CHAN_W +: CHAN_W];
            acc = ACC_W'(wc) * ACC_W'(a) + ACC_W'(in_word.w) * ACC_W'(b)
                + ACC_W'(W_ONE >> 1);
            rgb_next[c * CHAN_W +: CHAN_W] = acc[CHAN_W +: CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rgb_reg <= rgb_next;
    end

    assign out_rgb = rgb_reg;

endmodule

/* rtl/core/grc_sva.sv */
// ----------------------------------------------------------------------------
// grc_sva
// Port-level checks of the gradient row color block, bound to the top level.
// ----------------------------------------------------------------------------
module grc_sva (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a waiting word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // a waiting word keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output word changed while stalled");

    // no stall reaches the input while the sink takes words
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled with sink ready");

    // nothing comes out of reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    // no word is offered just as reset has been released
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_tvalid)
        else $error("output word without input");

endmodule

bind gradient_row_color grc_sva u_grc_sva (.*);
